### hw/rtl/piu_pkg.sv
`default_nettype none

package piu_pkg;

	// field and register widths
	localparam int DW_W       = 13;   // display width register
	localparam int DH_W       = 12;   // display height register
	localparam int POS_W      = DW_W + DH_W;
	localparam int OFF_W      = 24;
	localparam int COLOR_W    = 32;
	localparam int INDEX_W    = 8;
	localparam int SCALE_W    = 4;
	localparam int COORD_W    = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	// input item kinds
	localparam logic FUNC_PIXEL   = 1'b0;
	localparam logic FUNC_PALETTE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT = 1'd1;

	localparam logic [DW_W-1:0]    RESET_WIDTH  = 13'd1920;
	localparam logic [DH_W-1:0]    RESET_HEIGHT = 12'd1080;
	localparam logic [COLOR_W-1:0] BAR_COLOR    = 32'hFF00_0000;

	typedef struct packed {
		logic               func;
		logic [INDEX_W-1:0] pixel_index;
		logic [COLOR_W-1:0] palette_color;
	} piu_in_t;

	typedef struct packed {
		logic               buffer_select;
		logic [OFF_W-1:0]   pixel_offset;
		logic [OFF_W-1:0]   run_length;
		logic [COLOR_W-1:0] fill_color;
		logic               frame_done;
		logic               last;
	} piu_out_t;

	// one source pixel handed from front to back
	typedef struct packed {
		logic               buf_sel;
		logic               frame_end;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [COLOR_W-1:0] color;
	} piu_job_t;

	// letterbox geometry derived from the display registers
	typedef struct packed {
		logic [DW_W-1:0]    disp_w;
		logic [SCALE_W-1:0] scale;
		logic [DW_W-1:0]    gap;
		logic [DW_W-1:0]    off_x;
		logic [DH_W-1:0]    off_y;
		logic [POS_W-1:0]   bot_start;
		logic [POS_W-1:0]   bot_len;
	} piu_geo_t;

endpackage

`default_nettype wire

### hw/rtl/piu_ram.sv
`default_nettype none

module piu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/piu_geom.sv
`default_nettype none

module piu_geom import piu_pkg::*; #(
	parameter int SOURCE_WIDTH  = 320,
	parameter int SOURCE_HEIGHT = 200,
	parameter int MAX_SCALE     = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic                       busy,
	output piu_geo_t                   geo
);

	localparam logic [2:0] GEO_LAT = 3'd4;

	logic [DW_W-1:0]    disp_w_q;
	logic [DH_W-1:0]    disp_h_q;
	logic [2:0]         wait_q;
	logic               cfg_write;

	logic [DW_W-1:0]    wc;
	logic [DH_W-1:0]    hc;
	logic [SCALE_W-1:0] sc;
	logic [DW_W-1:0]    wc_s1;
	logic [DH_W-1:0]    hc_s1;
	logic [SCALE_W-1:0] sc_s1;

	logic [DW_W-1:0]    dst_w;
	logic [DH_W-1:0]    dst_h;
	logic [DW_W-1:0]    gap;
	logic [DH_W-1:0]    off_y;
	logic [DW_W-1:0]    wc_s2;
	logic [DH_W-1:0]    hc_s2;
	logic [SCALE_W-1:0] sc_s2;
	logic [DW_W-1:0]    gap_s2;
	logic [DW_W-1:0]    off_x_s2;
	logic [DH_W-1:0]    off_y_s2;
	logic [DW_W-1:0]    dst_w_s2;
	logic [DH_W-1:0]    bot_row_s2;

	logic [DW_W-1:0]    wc_s3;
	logic [SCALE_W-1:0] sc_s3;
	logic [DW_W-1:0]    gap_s3;
	logic [DW_W-1:0]    off_x_s3;
	logic [DH_W-1:0]    off_y_s3;
	logic [POS_W-1:0]   prod_s3;
	logic [POS_W-1:0]   area_s3;
	logic [DW_W-1:0]    end_col_s3;

	logic [DW_W-1:0]    wc_s4;
	logic [SCALE_W-1:0] sc_s4;
	logic [DW_W-1:0]    gap_s4;
	logic [DW_W-1:0]    off_x_s4;
	logic [DH_W-1:0]    off_y_s4;
	logic [POS_W-1:0]   bot_start_s4;
	logic [POS_W-1:0]   bot_len_s4;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid & cfg_ready;

	// display registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_w_q <= RESET_WIDTH;
			disp_h_q <= RESET_HEIGHT;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DISPLAY_WIDTH:  disp_w_q <= cfg_data;
				REG_DISPLAY_HEIGHT: disp_h_q <= cfg_data[DH_W-1:0];
				default: ;
			endcase
		end
	end

	// hold off new items until the geometry pipeline has settled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q <= GEO_LAT;
		end else if (cfg_write) begin
			wait_q <= GEO_LAT;
		end else if (wait_q != 3'd0) begin
			wait_q <= wait_q - 3'd1;
		end
	end

	assign busy = (wait_q != 3'd0);

	// stage 1: clamp the display to the source size, pick the largest scale that fits
	always_comb begin
		wc = (disp_w_q < DW_W'(SOURCE_WIDTH))  ? DW_W'(SOURCE_WIDTH)  : disp_w_q;
		hc = (disp_h_q < DH_W'(SOURCE_HEIGHT)) ? DH_W'(SOURCE_HEIGHT) : disp_h_q;
		sc = SCALE_W'(1);
		for (int k = 2; k <= MAX_SCALE; k++) begin
			if ((SOURCE_WIDTH * k) <= int'(wc) && (SOURCE_HEIGHT * k) <= int'(hc)) begin
				sc = SCALE_W'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		wc_s1 <= wc;
		hc_s1 <= hc;
		sc_s1 <= sc;
	end

	// stage 2: picture size, bars and centering offsets
	always_comb begin
		dst_w = DW_W'(SOURCE_WIDTH * int'(sc_s1));
		dst_h = DH_W'(SOURCE_HEIGHT * int'(sc_s1));
		gap   = wc_s1 - dst_w;
		off_y = (hc_s1 - dst_h) >> 1;
	end

	always_ff @(posedge clk) begin
		wc_s2      <= wc_s1;
		hc_s2      <= hc_s1;
		sc_s2      <= sc_s1;
		gap_s2     <= gap;
		off_x_s2   <= gap >> 1;
		off_y_s2   <= off_y;
		dst_w_s2   <= dst_w;
		bot_row_s2 <= off_y + dst_h - DH_W'(1);
	end

	// stage 3: row product of the bottom bar and the frame area
	always_ff @(posedge clk) begin
		wc_s3      <= wc_s2;
		sc_s3      <= sc_s2;
		gap_s3     <= gap_s2;
		off_x_s3   <= off_x_s2;
		off_y_s3   <= off_y_s2;
		prod_s3    <= POS_W'(bot_row_s2) * POS_W'(wc_s2);
		area_s3    <= POS_W'(wc_s2) * POS_W'(hc_s2);
		end_col_s3 <= off_x_s2 + dst_w_s2;
	end

	// stage 4: bottom bar start and length
	always_ff @(posedge clk) begin
		wc_s4        <= wc_s3;
		sc_s4        <= sc_s3;
		gap_s4       <= gap_s3;
		off_x_s4     <= off_x_s3;
		off_y_s4     <= off_y_s3;
		bot_start_s4 <= prod_s3 + POS_W'(end_col_s3);
		bot_len_s4   <= area_s3 - prod_s3 - POS_W'(end_col_s3);
	end

	always_comb begin
		geo.disp_w    = wc_s4;
		geo.scale     = sc_s4;
		geo.gap       = gap_s4;
		geo.off_x     = off_x_s4;
		geo.off_y     = off_y_s4;
		geo.bot_start = bot_start_s4;
		geo.bot_len   = bot_len_s4;
	end

endmodule

`default_nettype wire

### hw/rtl/piu_front.sv
`default_nettype none

module piu_front import piu_pkg::*; #(
	parameter int SOURCE_WIDTH  = 320,
	parameter int SOURCE_HEIGHT = 200,
	parameter int PALETTE_DEPTH = 256
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     pix_valid,
	output logic          pix_ready,
	input  wire piu_in_t  pix,
	input  wire logic     geo_busy,
	output logic          job_push,
	output piu_job_t      job,
	input  wire logic     job_full
);

	localparam int AW = $clog2(PALETTE_DEPTH);

	logic               accept;
	logic               is_pixel;
	logic               in_range;
	logic               frame_end;
	logic [COLOR_W-1:0] ram_rdata;

	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic               buf_q;

	logic               valid_s1;
	logic               hit_s1;
	logic               buf_s1;
	logic               frame_end_s1;
	logic [COORD_W-1:0] col_s1;
	logic [COORD_W-1:0] row_s1;

	assign pix_ready = !geo_busy && (!valid_s1 || !job_full);
	assign accept    = pix_valid & pix_ready;
	assign is_pixel  = (pix.func == FUNC_PIXEL);
	assign in_range  = ({1'b0, pix.pixel_index} < (INDEX_W + 1)'(PALETTE_DEPTH));
	assign frame_end = (col_q == COORD_W'(SOURCE_WIDTH - 1))
	                && (row_q == COORD_W'(SOURCE_HEIGHT - 1));

	// palette memory: written by entry writes, read by pixels
	piu_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (accept && !is_pixel && in_range),
		.waddr (pix.pixel_index[AW-1:0]),
		.wdata (pix.palette_color),
		.re    (accept && is_pixel),
		.raddr (pix.pixel_index[AW-1:0]),
		.rdata (ram_rdata)
	);

	// advance the raster position and flip the buffer at the end of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			buf_q <= 1'b0;
		end else if (accept && is_pixel) begin
			if (col_q == COORD_W'(SOURCE_WIDTH - 1)) begin
				col_q <= '0;
				row_q <= (row_q == COORD_W'(SOURCE_HEIGHT - 1)) ? '0 : row_q + COORD_W'(1);
			end else begin
				col_q <= col_q + COORD_W'(1);
			end
			if (frame_end) begin
				buf_q <= ~buf_q;
			end
		end
	end

	// hold the pixel while the palette read completes and until the queue has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && is_pixel) begin
			valid_s1 <= 1'b1;
		end else if (job_push && !job_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_pixel) begin
			hit_s1       <= in_range;
			buf_s1       <= buf_q;
			frame_end_s1 <= frame_end;
			col_s1       <= col_q;
			row_s1       <= row_q;
		end
	end

	assign job_push = valid_s1;

	always_comb begin
		job.buf_sel   = buf_s1;
		job.frame_end = frame_end_s1;
		job.col       = col_s1;
		job.row       = row_s1;
		job.color     = hit_s1 ? ram_rdata : '0;
	end

endmodule

`default_nettype wire

### hw/rtl/piu_fifo.sv
`default_nettype none

module piu_fifo import piu_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire piu_job_t push_data,
	output logic          full,
	input  wire logic     pop,
	output piu_job_t      pop_data,
	output logic          not_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	piu_job_t       mem_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/piu_back.sv
`default_nettype none

module piu_back import piu_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     job_valid,
	input  wire piu_job_t job,
	output logic          job_pop,
	input  wire piu_geo_t geo,
	output logic          run_valid,
	input  wire logic     run_ready,
	output piu_out_t      run
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MUL    = 5'b00010,
		ST_BAR    = 5'b00100,
		ST_COLOR  = 5'b01000,
		ST_BOTTOM = 5'b10000
	} piu_state_t;

	piu_state_t                 state_q;
	piu_state_t                 state_d;
	piu_job_t                   job_q;
	logic [DH_W-1:0]            yline_q;
	logic [POS_W-1:0]           row_start_q;
	logic [DW_W-1:0]            xs_q;
	logic [SCALE_W-1:0]         dy_q;
	logic                       run_valid_q;
	piu_out_t                   run_q;

	logic [COORD_W+SCALE_W-1:0] ys;
	logic [COORD_W+SCALE_W-1:0] xs;
	logic [POS_W-1:0]           row_prod;
	logic                       slot_free;
	logic                       first_row;
	logic                       last_dy;
	logic                       has_bottom;
	logic [POS_W-1:0]           bar_start;
	logic [POS_W-1:0]           bar_len;
	logic [POS_W-1:0]           color_start;
	logic                       load;
	logic                       adv_row;
	piu_out_t                   run_d;

	assign ys       = job.row * geo.scale;
	assign xs       = job_q.col * geo.scale;
	assign row_prod = POS_W'(yline_q) * POS_W'(geo.disp_w);

	assign slot_free   = !run_valid_q || run_ready;
	assign first_row   = (job_q.row == '0) && (dy_q == '0);
	assign last_dy     = (dy_q == geo.scale - SCALE_W'(1));
	assign has_bottom  = job_q.frame_end && (geo.bot_len != '0);
	assign bar_start   = first_row ? '0 : row_start_q - POS_W'(geo.gap);
	assign bar_len     = first_row ? row_start_q : POS_W'(geo.gap);
	assign color_start = row_start_q + POS_W'(xs_q);

	// run sequencer: left bar at a row start, colored run per scaled row, then the bottom bar at a frame end
	always_comb begin
		state_d             = state_q;
		load                = 1'b0;
		adv_row             = 1'b0;
		job_pop             = 1'b0;
		run_d.buffer_select = job_q.buf_sel;
		run_d.pixel_offset  = bar_start[OFF_W-1:0];
		run_d.run_length    = bar_len[OFF_W-1:0];
		run_d.fill_color    = BAR_COLOR;
		run_d.frame_done    = 1'b0;
		run_d.last          = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = (job_q.col == '0) ? ST_BAR : ST_COLOR;
			end
			ST_BAR: begin
				if (slot_free) begin
					// drop a bar of zero length
					load    = (bar_len != '0);
					state_d = ST_COLOR;
				end
			end
			ST_COLOR: begin
				if (slot_free) begin
					load               = 1'b1;
					run_d.pixel_offset = color_start[OFF_W-1:0];
					run_d.run_length   = OFF_W'(geo.scale);
					run_d.fill_color   = job_q.color;
					if (last_dy) begin
						run_d.last       = !has_bottom;
						run_d.frame_done = job_q.frame_end && !has_bottom;
						state_d          = has_bottom ? ST_BOTTOM : ST_IDLE;
					end else begin
						adv_row = 1'b1;
						state_d = (job_q.col == '0) ? ST_BAR : ST_COLOR;
					end
				end
			end
			ST_BOTTOM: begin
				if (slot_free) begin
					load               = 1'b1;
					run_d.pixel_offset = geo.bot_start[OFF_W-1:0];
					run_d.run_length   = geo.bot_len[OFF_W-1:0];
					run_d.frame_done   = 1'b1;
					run_d.last         = 1'b1;
					state_d            = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				run_valid_q <= 1'b1;
			end else if (run_ready) begin
				run_valid_q <= 1'b0;
			end
		end
	end

	// job registers, row address and output register
	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q   <= job;
			yline_q <= geo.off_y + DH_W'(ys);
		end
		if (state_q == ST_MUL) begin
			row_start_q <= row_prod + POS_W'(geo.off_x);
			xs_q        <= DW_W'(xs);
			dy_q        <= '0;
		end else if (adv_row) begin
			row_start_q <= row_start_q + POS_W'(geo.disp_w);
			dy_q        <= dy_q + SCALE_W'(1);
		end
		if (load) begin
			run_q <= run_d;
		end
	end

	assign run_valid = run_valid_q;
	assign run       = run_q;

endmodule

`default_nettype wire

### hw/rtl/palette_integer_upscaler.sv
// Channel | Direction | Handshake             | Payload
// pix     | in        | pix_valid / pix_ready | piu_in_t: palette write or source pixel
// run     | out       | run_valid / run_ready | piu_out_t: one fill run
// cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data: display registers
//
// In the back sequencer a source pixel is popped in ST_IDLE, addressed in ST_MUL, then
// gives a left bar at a row start and a colored run per scaled row, plus a bottom bar at
// a frame end; one run per cycle while run_ready allows, bounded by the single run output
// register. After reset and after every register write, pix_ready stays low while the
// geometry pipeline settles. A two-entry queue lets the front keep taking items while the
// back waits on run_ready; the front stalls only on a full queue or a busy geometry.
`default_nettype none

module palette_integer_upscaler import piu_pkg::*; #(
	parameter int SOURCE_WIDTH  = 320,
	parameter int SOURCE_HEIGHT = 200,
	parameter int MAX_SCALE     = 8,
	parameter int PALETTE_DEPTH = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  pix_valid,
	output logic                       pix_ready,
	input  wire piu_in_t               pix,
	output logic                       run_valid,
	input  wire logic                  run_ready,
	output piu_out_t                   run,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic     geo_busy;
	piu_geo_t geo;
	logic     job_push;
	piu_job_t job_in;
	logic     job_full;
	logic     job_pop;
	piu_job_t job_out;
	logic     job_valid;

	piu_geom #(
		.SOURCE_WIDTH  (SOURCE_WIDTH),
		.SOURCE_HEIGHT (SOURCE_HEIGHT),
		.MAX_SCALE     (MAX_SCALE)
	) u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (geo_busy),
		.geo       (geo)
	);

	piu_front #(
		.SOURCE_WIDTH  (SOURCE_WIDTH),
		.SOURCE_HEIGHT (SOURCE_HEIGHT),
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.geo_busy  (geo_busy),
		.job_push  (job_push),
		.job       (job_in),
		.job_full  (job_full)
	);

	piu_fifo #(
		.DEPTH (2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.full      (job_full),
		.pop       (job_pop),
		.pop_data  (job_out),
		.not_empty (job_valid)
	);

	piu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job_out),
		.job_pop   (job_pop),
		.geo       (geo),
		.run_valid (run_valid),
		.run_ready (run_ready),
		.run       (run)
	);

endmodule

`default_nettype wire

### hw/rtl/piu_check.sv
`default_nettype none

module piu_check import piu_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     pix_ready,
	input wire logic     run_valid,
	input wire logic     run_ready,
	input wire piu_out_t run,
	input wire logic     cfg_valid,
	input wire logic     cfg_ready
);

	// a register write blocks new items while the geometry settles
	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !pix_ready)
		else $error("pixel accepted right after a register write");

	// no item is taken in the first cycle out of reset
	a_reset_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !pix_ready)
		else $error("pix_ready high right after reset");

	// the frame flip always closes the runs of its pixel
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && run.frame_done |-> run.last)
		else $error("frame_done without last");

	// a stalled run holds
	a_run_hold: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && !run_ready |=> run_valid && $stable(run))
		else $error("run changed while stalled");

endmodule

bind palette_integer_upscaler piu_check u_piu_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_ready (pix_ready),
	.run_valid (run_valid),
	.run_ready (run_ready),
	.run       (run),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

`default_nettype wire
